### rtl/core/cmtt_pkg.sv
`default_nettype none

package cmtt_pkg;

    localparam int MATRIX_DIM_DEF = 3;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 28;

    localparam int IN_ELEM_W = 32;
    localparam int OUT_W     = 48;
    localparam int POS_W     = 2;
    localparam int MID_W     = 2;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 96;

    localparam logic [MID_W-1:0] MAT_ID_A = 2'd0;
    localparam logic [MID_W-1:0] MAT_ID_B = 2'd1;
    localparam logic [MID_W-1:0] MAT_ID_C = 2'd2;

    localparam logic MODE_ABC     = 1'b0;
    localparam logic MODE_ABC_DAG = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AB_RD,
        ST_AB_MUL,
        ST_C_RD,
        ST_P_SAT,
        ST_C_MUL,
        ST_T_DRAIN,
        ST_T_ACC,
        ST_DONE
    } cmtt_state_t;

endpackage

`default_nettype wire

### rtl/core/cmtt_ram.sv
`default_nettype none

module cmtt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 27
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
    output      logic [WIDTH-1:0]         rd_data0,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
    output      logic [WIDTH-1:0]         rd_data1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

`default_nettype wire

### rtl/core/complex_three_matrix_trace_top.sv
// Trace of A*B*C or A*B*C^dagger over three complex MATRIX_DIM square matrices.
// Input stream: one matrix element per request, written into an internal
// dual-read RAM (3*MATRIX_DIM^2 entries). Requests are taken one per cycle
// while the unit is idle; a request with tlast starts the trace pass after
// its own element is stored. A request with an out-of-range matrix, row or
// column stores nothing.
// The pass runs on one shared signed ELEM_WIDTH x ELEM_WIDTH multiplier, one
// real product per cycle in the multiply states. Per (i,j) it reads A and B
// and multiplies them for each k, then reads C, saturates the partial
// product, multiplies it by C and adds it to the trace; the result then lands
// in the output register. Input is held off during the pass. The result
// register holds while m_tready is low; loads for the next set are accepted
// meanwhile, and a new pass waits to deliver until the old result is taken.
// cfg_data bit 0 selects the mode (0: A*B*C, 1: A*B*C^dagger); write only when
// idle. Reset (aresetn low, synchronous) clears control state and the mode;
// RAM contents are undefined until loaded.
`default_nettype none

module complex_three_matrix_trace_top #(
    parameter int MATRIX_DIM = cmtt_pkg::MATRIX_DIM_DEF,
    parameter int ELEM_WIDTH = cmtt_pkg::ELEM_WIDTH_DEF,
    parameter int FRAC_BITS  = cmtt_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // row_index[1:0], col_index[3:2], elem_re[35:4], elem_im[67:36], zero pad
    input  wire logic [cmtt_pkg::S_TDATA_W-1:0] s_tdata,
    // matrix_id[1:0]
    input  wire logic [cmtt_pkg::MID_W-1:0]     s_tuser,
    input  wire logic                           s_tlast,

    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // trace_re[47:0], trace_im[95:48]
    output      logic [cmtt_pkg::M_TDATA_W-1:0] m_tdata,
    // overflow_flag[0]
    output      logic                           m_tuser,

    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic                           cfg_data
);

    import cmtt_pkg::*;

    localparam int MAT_SIZE = MATRIX_DIM * MATRIX_DIM;
    localparam int DEPTH    = 3 * MAT_SIZE;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(MATRIX_DIM);
    localparam int E        = ELEM_WIDTH;
    localparam int MW       = 2 * E - FRAC_BITS;
    localparam int PAW      = MW + $clog2(2 * MATRIX_DIM) + 1;
    localparam int TW       = MW + 2;
    localparam int SW       = ((TW > OUT_W) ? TW : OUT_W) + 1;

    localparam logic [CW-1:0] DIM_LAST = CW'(MATRIX_DIM - 1);
    localparam logic [3:0]    DIM_L    = 4'(MATRIX_DIM);
    localparam logic [AW-1:0] DIM_A    = AW'(MATRIX_DIM);
    localparam logic [AW-1:0] B_BASE   = AW'(MAT_SIZE);
    localparam logic [AW-1:0] C_BASE   = AW'(2 * MAT_SIZE);

    localparam logic signed [PAW-1:0] P_HI = {{(PAW-E+1){1'b0}}, {(E-1){1'b1}}};
    localparam logic signed [PAW-1:0] P_LO = ~P_HI;
    localparam logic signed [SW-1:0]  S_HI = {{(SW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SW-1:0]  S_LO = ~S_HI;

    cmtt_state_t state_reg, state_next;

    logic [CW-1:0] i_reg, j_reg, k_reg;
    logic [1:0]    ph_reg;
    logic          mode_reg;

    logic          mul_vld_reg, mul_im_reg, mul_neg_reg, mul_c_reg;
    logic signed [MW-1:0]  prod_reg;
    logic signed [PAW-1:0] pr_reg, pi_reg;
    logic signed [E-1:0]   p_re_reg, p_im_reg;
    logic signed [TW-1:0]  tr_reg, ti_reg;
    logic signed [OUT_W-1:0] acc_re_reg, acc_im_reg;
    logic          ovf_reg;

    logic          m_valid_reg, m_ovf_reg;
    logic signed [OUT_W-1:0] m_re_reg, m_im_reg;

    // control
    logic s_acc, load_start, c_sel, mul_go, out_load;

    // ram
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;
    logic [2*E-1:0] wr_data, rd_data0, rd_data1;

    // input fields
    logic [MID_W-1:0] in_mid;
    logic [POS_W-1:0] in_row, in_col;
    logic [IN_ELEM_W-1:0] in_re, in_im;

    assign in_mid = s_tuser;
    assign in_row = s_tdata[1:0];
    assign in_col = s_tdata[3:2];
    assign in_re  = s_tdata[35:4];
    assign in_im  = s_tdata[67:36];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tlast) begin
                    state_next = ST_AB_RD;
                end
            end
            ST_AB_RD:  state_next = ST_AB_MUL;
            ST_AB_MUL: begin
                if (ph_reg == 2'd3) begin
                    state_next = (k_reg == DIM_LAST) ? ST_C_RD : ST_AB_RD;
                end
            end
            ST_C_RD:  state_next = ST_P_SAT;
            ST_P_SAT: state_next = ST_C_MUL;
            ST_C_MUL: begin
                if (ph_reg == 2'd3) begin
                    state_next = ST_T_DRAIN;
                end
            end
            ST_T_DRAIN: state_next = ST_T_ACC;
            ST_T_ACC: begin
                if (i_reg == DIM_LAST && j_reg == DIM_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_AB_RD;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        load_start = (state_reg == ST_IDLE) && s_acc && s_tlast;
        c_sel      = state_reg inside {ST_C_RD, ST_P_SAT, ST_C_MUL};
        mul_go     = state_reg inside {ST_AB_MUL, ST_C_MUL};
        out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    end

    // store write
    always_comb begin
        wr_en   = s_acc && (in_mid <= MAT_ID_C)
                  && ({2'b00, in_row} < DIM_L) && ({2'b00, in_col} < DIM_L);
        wr_addr = AW'(in_mid) * B_BASE + AW'(in_row) * DIM_A + AW'(in_col);
        wr_data = {in_im[E-1:0], in_re[E-1:0]};
    end

    // store read
    always_comb begin
        if (c_sel) begin
            if (mode_reg == MODE_ABC_DAG) begin
                rd_addr0 = C_BASE + AW'(i_reg) * DIM_A + AW'(j_reg);
            end else begin
                rd_addr0 = C_BASE + AW'(j_reg) * DIM_A + AW'(i_reg);
            end
        end else begin
            rd_addr0 = AW'(i_reg) * DIM_A + AW'(k_reg);
        end
        rd_addr1 = B_BASE + AW'(k_reg) * DIM_A + AW'(j_reg);
    end

    cmtt_ram #(
        .WIDTH (2 * E),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_addr0),
        .rd_data0 (rd_data0),
        .rd_addr1 (rd_addr1),
        .rd_data1 (rd_data1)
    );

    // shared multiplier: ph[0] picks imag of left operand, ph[0]^ph[1] of right
    logic signed [E-1:0]   op_a, op_b;
    logic signed [2*E-1:0] prod;
    logic                  op_b_im, term_neg;

    always_comb begin
        op_b_im = ph_reg[0] ^ ph_reg[1];
        if (c_sel) begin
            op_a = ph_reg[0] ? p_im_reg : p_re_reg;
            op_b = op_b_im ? rd_data0[2*E-1:E] : rd_data0[E-1:0];
        end else begin
            op_a = ph_reg[0] ? rd_data0[2*E-1:E] : rd_data0[E-1:0];
            op_b = op_b_im ? rd_data1[2*E-1:E] : rd_data1[E-1:0];
        end
        prod = op_a * op_b;
        if (c_sel) begin
            term_neg = ((ph_reg == 2'd1) && (mode_reg == MODE_ABC))
                    || ((ph_reg == 2'd2) && (mode_reg == MODE_ABC_DAG));
        end else begin
            term_neg = (ph_reg == 2'd1);
        end
    end

    // accumulate terms
    logic signed [PAW-1:0] p_term;
    logic signed [TW-1:0]  t_term;
    logic signed [SW-1:0]  sum_re, sum_im;
    logic                  pr_hi, pr_lo, pi_hi, pi_lo;
    logic                  sr_hi, sr_lo, si_hi, si_lo;

    always_comb begin
        p_term = mul_neg_reg ? -PAW'(prod_reg) : PAW'(prod_reg);
        t_term = mul_neg_reg ? -TW'(prod_reg) : TW'(prod_reg);
        pr_hi  = pr_reg > P_HI;
        pr_lo  = pr_reg < P_LO;
        pi_hi  = pi_reg > P_HI;
        pi_lo  = pi_reg < P_LO;
        sum_re = SW'(acc_re_reg) + SW'(tr_reg);
        sum_im = SW'(acc_im_reg) + SW'(ti_reg);
        sr_hi  = sum_re > S_HI;
        sr_lo  = sum_re < S_LO;
        si_hi  = sum_im > S_HI;
        si_lo  = sum_im < S_LO;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_ABC;
            mul_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            ph_reg      <= '0;
            ovf_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end

            mul_vld_reg <= mul_go;

            if (load_start) begin
                i_reg   <= '0;
                j_reg   <= '0;
                k_reg   <= '0;
                ph_reg  <= '0;
                ovf_reg <= 1'b0;
            end
            if (mul_go) begin
                ph_reg <= ph_reg + 2'd1;
            end
            if (state_reg == ST_AB_MUL && ph_reg == 2'd3) begin
                k_reg <= (k_reg == DIM_LAST) ? '0 : k_reg + CW'(1);
            end
            if (state_reg == ST_P_SAT && (pr_hi || pr_lo || pi_hi || pi_lo)) begin
                ovf_reg <= 1'b1;
            end
            if (state_reg == ST_T_ACC) begin
                if (sr_hi || sr_lo || si_hi || si_lo) begin
                    ovf_reg <= 1'b1;
                end
                if (j_reg == DIM_LAST) begin
                    j_reg <= '0;
                    i_reg <= i_reg + CW'(1);
                end else begin
                    j_reg <= j_reg + CW'(1);
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        prod_reg    <= prod[2*E-1:FRAC_BITS];
        mul_im_reg  <= ph_reg[1];
        mul_neg_reg <= term_neg;
        mul_c_reg   <= c_sel;

        if (load_start || state_reg == ST_T_ACC) begin
            pr_reg <= '0;
            pi_reg <= '0;
        end else if (mul_vld_reg && !mul_c_reg) begin
            if (mul_im_reg) begin
                pi_reg <= pi_reg + p_term;
            end else begin
                pr_reg <= pr_reg + p_term;
            end
        end

        if (state_reg == ST_P_SAT) begin
            p_re_reg <= pr_hi ? P_HI[E-1:0] : (pr_lo ? P_LO[E-1:0] : pr_reg[E-1:0]);
            p_im_reg <= pi_hi ? P_HI[E-1:0] : (pi_lo ? P_LO[E-1:0] : pi_reg[E-1:0]);
            tr_reg   <= '0;
            ti_reg   <= '0;
        end else if (mul_vld_reg && mul_c_reg) begin
            if (mul_im_reg) begin
                ti_reg <= ti_reg + t_term;
            end else begin
                tr_reg <= tr_reg + t_term;
            end
        end

        if (load_start) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (state_reg == ST_T_ACC) begin
            acc_re_reg <= sr_hi ? S_HI[OUT_W-1:0] : (sr_lo ? S_LO[OUT_W-1:0] : sum_re[OUT_W-1:0]);
            acc_im_reg <= si_hi ? S_HI[OUT_W-1:0] : (si_lo ? S_LO[OUT_W-1:0] : sum_im[OUT_W-1:0]);
        end

        if (out_load) begin
            m_re_reg  <= acc_re_reg;
            m_im_reg  <= acc_im_reg;
            m_ovf_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_im_reg, m_re_reg};
    assign m_tuser  = m_ovf_reg;

endmodule

`default_nettype wire
